/* rtl/bab_pkg.sv */
// ---------------------------------------------------------------------------
// bab_pkg
// Shared types, register indexes and helpers for the bit-aligned OR blitter.
// ---------------------------------------------------------------------------
package bab_pkg;

    // Row limit; a larger row_count acts as this value
    localparam int MAX_ROWS  = 256;

    // Field widths
    localparam int COL_W     = 13;
    localparam int ROWS_W    = 9;
    localparam int WORD_W    = 16;
    localparam int WIN_W     = 32;
    localparam int DROW_W    = 8;
    localparam int DIDX_W    = 9;
    localparam int CNT_W     = 9;
    localparam int TRIG_W    = 10;
    localparam int SHIFT_W   = 4;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_FIRST_COL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_END_COL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_FIRST_COL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ITALIC_ENABLE = 3'd4;

    // Configuration register set
    typedef struct packed {
        logic [COL_W-1:0]  src_first_col;
        logic [COL_W-1:0]  src_end_col;
        logic [COL_W-1:0]  dst_first_col;
        logic [ROWS_W-1:0] row_count;
        logic              italic_enable;
    } t_cfg;

    // Per-row geometry handed from the geometry unit to the datapath
    typedef struct packed {
        logic [TRIG_W-1:0]  trigger;
        logic [DIDX_W-1:0]  base;
        logic [CNT_W-1:0]   writes;
        logic [SHIFT_W-1:0] shift;
        logic [WIN_W-1:0]   fmask;
        logic [WIN_W-1:0]   lmask;
    } t_geom;

    // One result word
    typedef struct packed {
        logic [DROW_W-1:0] dst_row;
        logic [DIDX_W-1:0] dst_word_index;
        logic [WORD_W-1:0] or_bits;
        logic              last_of_row;
    } t_res;

    // Row count clamped to the row limit
    function automatic logic [ROWS_W-1:0] eff_rows(input logic [ROWS_W-1:0] row_count);
        logic [ROWS_W-1:0] lim;
        lim = ROWS_W'(MAX_ROWS);
        return (row_count > lim) ? lim : row_count;
    endfunction

endpackage

/* rtl/bab_if.sv */
// ---------------------------------------------------------------------------
// bab_if
// Valid/ready channels of the blitter: source words, results, config writes.
// ---------------------------------------------------------------------------

// Source word channel
interface bab_word_if import bab_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] src_word;
    logic              row_end;

    modport source (output valid, output src_word, output row_end, input ready);
    modport sink   (input valid, input src_word, input row_end, output ready);
endinterface

// Result word channel
interface bab_res_if import bab_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DROW_W-1:0] dst_row;
    logic [DIDX_W-1:0] dst_word_index;
    logic [WORD_W-1:0] or_bits;
    logic              last_of_row;

    modport source (output valid, output dst_row, output dst_word_index,
                    output or_bits, output last_of_row, input ready);
    modport sink   (input valid, input dst_row, input dst_word_index,
                    input or_bits, input last_of_row, output ready);
endinterface

// Configuration write channel
interface bab_cfg_if import bab_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COL_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/bit_aligned_or_blit_rows.sv */
// Output: a write is registered in the main slot, or the skid slot on a stall.
// Throughput: one source word per cycle unless a restart or a full skid slot holds it;
// the funnel window and masks sit between the row state registers and result register.
// A config register write sets the restart flag; no source word is taken while it is set.
// Reset: synchronous, active low; control registers cleared, row state not; idle until configured.
// ---------------------------------------------------------------------------
// bit_aligned_or_blit_rows
// Bit-aligned OR blit of a column span, one row of source words at a time.
// ---------------------------------------------------------------------------
module bit_aligned_or_blit_rows import bab_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bab_word_if.sink    i_word,
    bab_res_if.source   o_res,
    bab_cfg_if.sink     i_cfg
);

    // Configuration and control
    t_cfg               r_cfg, n_cfg;
    logic               r_restart, n_restart;
    logic               r_idle, n_idle;

    // Row state
    logic [DROW_W-1:0]  r_row_index, n_row_index;
    logic [WIN_W-1:0]   r_window, n_window;
    logic [CNT_W-1:0]   r_word_count, n_word_count;
    logic [SHIFT_W-1:0] r_shift, n_shift;
    logic [WIN_W-1:0]   r_fmask, n_fmask;
    logic [WIN_W-1:0]   r_lmask, n_lmask;
    logic [TRIG_W-1:0]  r_trigger, n_trigger;
    logic [CNT_W-1:0]   r_writes_left, n_writes_left;
    logic [DIDX_W-1:0]  r_dst_word, n_dst_word;

    logic               cfg_acc;
    logic               in_acc;
    logic               step;
    logic               fire;
    logic               last;
    logic               buf_full;
    logic [ROWS_W-1:0]  rows;
    logic [ROWS_W-1:0]  row_nxt;
    logic [ROWS_W-1:0]  geom_row;
    logic [WIN_W-1:0]   win_shift;
    logic [WIN_W-1:0]   win_new;
    logic [WIN_W-1:0]   win_masked;
    logic [WIN_W-1:0]   win_aligned;
    t_geom              geom;
    t_res               res;

    // Handshakes
    assign i_cfg.ready  = 1'b1;
    assign cfg_acc      = i_cfg.valid && i_cfg.ready;
    assign i_word.ready = !r_restart && !buf_full;
    assign in_acc       = i_word.valid && i_word.ready;
    assign step         = in_acc && !r_idle;

    // Geometry of row 0 on restart, otherwise of the following row
    assign rows     = eff_rows(r_cfg.row_count);
    assign row_nxt  = {1'b0, r_row_index} + 9'd1;
    assign geom_row = r_restart ? '0 : row_nxt;

    bab_geom u_geom (
        .i_cfg  (r_cfg),
        .i_row  (geom_row),
        .o_geom (geom)
    );

    // Funnel window, first mask and write decision
    assign win_shift   = {r_window[15:0], i_word.src_word};
    assign win_new     = ({1'b0, r_word_count} == r_trigger) ? (win_shift & r_fmask)
                                                              : win_shift;
    assign fire        = step && ({1'b0, r_word_count} >= r_trigger)
                         && (r_writes_left != '0);
    assign last        = r_writes_left == 9'd1;
    assign win_masked  = last ? (win_new & r_lmask) : win_new;
    assign win_aligned = win_masked >> r_shift;

    always_comb begin
        res.dst_row        = r_row_index;
        res.dst_word_index = r_dst_word;
        res.or_bits        = win_aligned[15:0];
        res.last_of_row    = last;
    end

    // Next state
    always_comb begin
        n_cfg         = r_cfg;
        n_restart     = 1'b0;
        n_idle        = r_idle;
        n_row_index   = r_row_index;
        n_window      = r_window;
        n_word_count  = r_word_count;
        n_shift       = r_shift;
        n_fmask       = r_fmask;
        n_lmask       = r_lmask;
        n_trigger     = r_trigger;
        n_writes_left = r_writes_left;
        n_dst_word    = r_dst_word;

        if (r_restart) begin
            // restart at row 0
            n_row_index   = '0;
            n_idle        = (rows == '0) || (r_cfg.src_end_col <= r_cfg.src_first_col);
            n_window      = '0;
            n_word_count  = '0;
            n_shift       = geom.shift;
            n_fmask       = geom.fmask;
            n_lmask       = geom.lmask;
            n_trigger     = geom.trigger;
            n_writes_left = geom.writes;
            n_dst_word    = geom.base;
        end else if (step) begin
            n_window = win_new;
            if (r_word_count != 9'd511) begin
                n_word_count = r_word_count + 9'd1;
            end
            if (fire) begin
                n_writes_left = r_writes_left - 9'd1;
                n_dst_word    = r_dst_word + 9'd1;
            end
            if (i_word.row_end) begin
                if (row_nxt >= rows) begin
                    n_idle        = 1'b1;
                    n_writes_left = '0;
                end else begin
                    n_row_index   = row_nxt[7:0];
                    n_window      = '0;
                    n_word_count  = '0;
                    n_shift       = geom.shift;
                    n_fmask       = geom.fmask;
                    n_lmask       = geom.lmask;
                    n_trigger     = geom.trigger;
                    n_writes_left = geom.writes;
                    n_dst_word    = geom.base;
                end
            end
        end

        // Register writes restart the blit; a write to an unknown index does not
        if (cfg_acc) begin
            case (i_cfg.index)
                CFG_SRC_FIRST_COL: begin
                    n_cfg.src_first_col = i_cfg.data;
                    n_restart           = 1'b1;
                end
                CFG_SRC_END_COL: begin
                    n_cfg.src_end_col = i_cfg.data;
                    n_restart         = 1'b1;
                end
                CFG_DST_FIRST_COL: begin
                    n_cfg.dst_first_col = i_cfg.data;
                    n_restart           = 1'b1;
                end
                CFG_ROW_COUNT: begin
                    n_cfg.row_count = i_cfg.data[8:0];
                    n_restart       = 1'b1;
                end
                CFG_ITALIC_ENABLE: begin
                    n_cfg.italic_enable = i_cfg.data[0];
                    n_restart           = 1'b1;
                end
                default: begin
                    n_restart = 1'b0;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= '0;
            r_restart <= 1'b0;
            r_idle    <= 1'b1;
        end else begin
            r_cfg     <= n_cfg;
            r_restart <= n_restart;
            r_idle    <= n_idle;
        end
    end

    // Row state, loaded at every restart before use
    always_ff @(posedge i_clk) begin
        r_row_index   <= n_row_index;
        r_window      <= n_window;
        r_word_count  <= n_word_count;
        r_shift       <= n_shift;
        r_fmask       <= n_fmask;
        r_lmask       <= n_lmask;
        r_trigger     <= n_trigger;
        r_writes_left <= n_writes_left;
        r_dst_word    <= n_dst_word;
    end

    // Result register and skid stage
    bab_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (res),
        .o_full  (buf_full),
        .o_res   (o_res)
    );

    // Restart lasts a single cycle unless another register write arrives
    a_restart_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_restart && !cfg_acc) |=> !r_restart)
        else $error("restart held past one cycle");

    // Once idle, the blitter stays idle until reconfigured
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idle && !r_restart && !cfg_acc) |=> r_idle)
        else $error("left idle without a register write");

    // The write marked last of row exhausts the row's write count
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res.last_of_row && !i_word.row_end) |=> (r_writes_left == '0))
        else $error("writes remain after last write of row");

    // Destination word advances by one per write within a row
    a_word_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !i_word.row_end) |=> (r_dst_word == $past(r_dst_word) + 9'd1))
        else $error("destination word did not advance");

endmodule

/* rtl/bab_geom.sv */
// ---------------------------------------------------------------------------
// bab_geom
// Row geometry: italic offset, funnel shift, masks, trigger and write count.
// ---------------------------------------------------------------------------
module bab_geom import bab_pkg::*; (
    input  t_cfg              i_cfg,
    input  logic [ROWS_W-1:0] i_row,
    output t_geom             o_geom
);

    logic [ROWS_W-1:0]  rows;
    logic [ROWS_W-1:0]  diff;
    logic [7:0]         off;
    logic [COL_W:0]     dcol;
    logic [COL_W-1:0]   len;
    logic [COL_W:0]     span;
    logic [TRIG_W-1:0]  wtd;
    logic [CNT_W-1:0]   wfd;
    logic [3:0]         ftm;
    logic [3:0]         fme;
    logic [3:0]         lme;
    logic [3:0]         dend_lo;
    logic               neg;
    logic               lm_short;

    // Italic slant offset for this row
    always_comb begin
        rows = eff_rows(i_cfg.row_count);
        diff = rows - 9'd1 - i_row;
        if (!i_cfg.italic_enable) begin
            off = 8'd0;
        end else if (i_row == '0) begin
            off = rows[8:1];
        end else if (i_row < rows) begin
            off = diff[8:1];
        end else begin
            off = 8'd0;
        end
    end

    // Column arithmetic; word span taken from the low nibble plus length
    assign dcol    = {1'b0, i_cfg.dst_first_col} + {6'd0, off};
    assign len     = i_cfg.src_end_col - i_cfg.src_first_col;
    assign ftm     = dcol[3:0];
    assign fme     = i_cfg.src_first_col[3:0];
    assign lme     = i_cfg.src_end_col[3:0];
    assign span    = {10'd0, ftm} + {1'b0, len};
    assign wtd     = span[13:4];
    assign dend_lo = span[3:0];
    assign wfd     = i_cfg.src_end_col[12:4] - i_cfg.src_first_col[12:4];
    assign neg     = ftm < fme;
    assign lm_short = (wtd > {1'b0, wfd}) || (dend_lo < lme);

    // Masks, shift and counts
    always_comb begin
        o_geom.shift   = ftm - fme;
        o_geom.fmask   = neg ? (32'hFFFF_FFFF >> fme) : (32'h0000_FFFF >> fme);
        o_geom.trigger = {1'b0, i_cfg.src_first_col[12:4]} + {9'd0, neg};
        o_geom.lmask   = lm_short ? ~(32'hFFFF_FFFF >> lme)
                                  : ~(32'hFFFF_FFFF >> (6'd16 + {2'd0, lme}));
        o_geom.base    = dcol[12:4];
        o_geom.writes  = (wtd >= 10'd511) ? 9'd511 : (wtd[8:0] + 9'd1);
    end

endmodule

/* rtl/bab_out_buf.sv */
// ---------------------------------------------------------------------------
// bab_out_buf
// Result register with a skid stage so the datapath runs on until the skid slot is full.
// ---------------------------------------------------------------------------
module bab_out_buf import bab_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_res             i_data,
    output logic             o_full,
    bab_res_if.source        o_res
);

    logic r_main_valid, n_main_valid;
    logic r_skid_valid, n_skid_valid;
    t_res r_main, n_main;
    t_res r_skid, n_skid;
    logic pop;

    assign pop    = r_main_valid && o_res.ready;
    assign o_full = r_skid_valid;

    // Next state of main and skid slots
    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (pop) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                n_main       = i_data;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_main_valid = 1'b0;
        end
    end

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_res.valid          = r_main_valid;
    assign o_res.dst_row        = r_main.dst_row;
    assign o_res.dst_word_index = r_main.dst_word_index;
    assign o_res.or_bits        = r_main.or_bits;
    assign o_res.last_of_row    = r_main.last_of_row;

endmodule

/* tb/bab_blit_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bab_blit_checker
// Watches the config, source word and result channels of the OR blitter.
// Keeps its own row layout and funnel window state, works out the write
// each accepted source word makes, and compares every accepted result word
// field by field against the oldest pending write.
// ---------------------------------------------------------------------------
module bab_blit_checker import bab_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bab_word_if  i_word,
    bab_res_if   i_res,
    bab_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_pending
);

    // Register copy and blit state
    t_cfg             cfg = '0;
    logic [WIN_W-1:0] win = '0;
    logic [WIN_W-1:0] fmask_r = '0;
    logic [WIN_W-1:0] lmask_r = '0;
    logic [3:0]       row_shift = '0;
    int unsigned      row_idx = 0;
    int unsigned      word_cnt = 0;
    int unsigned      writes_left = 0;
    bit               blit_idle = 1'b1;
    int               mismatches = 0;

    // Writes expected on the result channel, oldest first
    t_res pending_writes[$];

    // Row count clamped to the row limit
    function automatic int unsigned rows_in_use(input t_cfg c);
        return (c.row_count > MAX_ROWS) ? MAX_ROWS : c.row_count;
    endfunction

    // Placement of one row: slant offset, shift, masks, first write and count
    function automatic t_geom span_layout(input t_cfg c, input int unsigned r);
        t_geom       g;
        int unsigned rows, off, first, last_col, len, dcol, dend, wtd, wfd;
        int unsigned fme, lme, ftm;
        int          sh;
        logic [63:0] ones;
        rows     = rows_in_use(c);
        first    = c.src_first_col;
        last_col = c.src_end_col;
        off      = 0;
        if (c.italic_enable) begin
            if (r == 0) off = rows / 2;
            else if (r < rows) off = (rows - 1 - r) / 2;
        end
        len  = (last_col > first) ? last_col - first : 0;
        dcol = c.dst_first_col + off;
        dend = dcol + len;
        wtd  = (dend >> 4) - (dcol >> 4);
        wfd  = (last_col >> 4) - (first >> 4);
        lme  = last_col & 15;
        fme  = first & 15;
        ftm  = dcol & 15;
        sh   = int'(ftm) - int'(fme);
        // source bits start right of the target bits: one more word first
        if (sh < 0) begin
            sh        = sh + 16;
            g.fmask   = 32'hFFFF_FFFF >> fme;
            g.trigger = TRIG_W'((first >> 4) + 1);
        end else begin
            g.fmask   = 32'h0000_FFFF >> fme;
            g.trigger = TRIG_W'(first >> 4);
        end
        g.shift = SHIFT_W'(sh);
        ones    = 64'h0000_0000_FFFF_FFFF;
        // last mask sits in the upper half when the tail spills a word
        if (wtd > wfd || (dend & 15) < lme) g.lmask = WIN_W'(ones << (32 - lme));
        else g.lmask = WIN_W'(ones << (16 - lme));
        g.base   = DIDX_W'(dcol >> 4);
        g.writes = CNT_W'((wtd + 1 > 511) ? 511 : wtd + 1);
        return g;
    endfunction

    task automatic load_row();
        t_geom g;
        g           = span_layout(cfg, row_idx);
        win         = '0;
        word_cnt    = 0;
        row_shift   = g.shift;
        fmask_r     = g.fmask;
        lmask_r     = g.lmask;
        writes_left = g.writes;
    endtask

    task automatic restart_blit();
        row_idx     = 0;
        win         = '0;
        word_cnt    = 0;
        row_shift   = '0;
        fmask_r     = '0;
        lmask_r     = '0;
        writes_left = 0;
        blit_idle   = (rows_in_use(cfg) == 0) || (cfg.src_end_col <= cfg.src_first_col);
        if (!blit_idle) load_row();
    endtask

    // Register write; an unknown index leaves everything as it is
    task automatic take_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COL_W-1:0] data);
        case (idx)
            CFG_SRC_FIRST_COL: cfg.src_first_col = data;
            CFG_SRC_END_COL:   cfg.src_end_col   = data;
            CFG_DST_FIRST_COL: cfg.dst_first_col = data;
            CFG_ROW_COUNT:     cfg.row_count     = data[ROWS_W-1:0];
            CFG_ITALIC_ENABLE: cfg.italic_enable = data[0];
            default:           return;
        endcase
        restart_blit();
    endtask

    // One source word through the funnel window; queues the write it makes
    task automatic blit_word(input logic [WORD_W-1:0] w, input logic row_end);
        t_geom            g;
        t_res             wr;
        bit               last;
        logic [WIN_W-1:0] v;
        int unsigned      p, k;
        if (blit_idle) return;
        g   = span_layout(cfg, row_idx);
        p   = word_cnt;
        win = {win[15:0], w};
        if (p == g.trigger) win = win & fmask_r;
        if (p >= g.trigger && writes_left > 0) begin
            last              = (writes_left == 1);
            k                 = g.writes - writes_left;
            v                 = last ? (win & lmask_r) : win;
            wr.dst_row        = DROW_W'(row_idx);
            wr.dst_word_index = DIDX_W'(g.base + k);
            wr.or_bits        = WORD_W'(v >> row_shift);
            wr.last_of_row    = last;
            pending_writes.push_back(wr);
            writes_left--;
        end
        if (word_cnt < 511) word_cnt++;
        // row done: next row, or finished after the last one
        if (row_end) begin
            row_idx++;
            if (row_idx >= rows_in_use(cfg)) begin
                blit_idle   = 1'b1;
                writes_left = 0;
            end else begin
                load_row();
            end
        end
    endtask

    task automatic check_write();
        t_res want;
        if (pending_writes.size() == 0) begin
            $error("result word with no write pending: row %0d word %0d bits %h",
                   i_res.dst_row, i_res.dst_word_index, i_res.or_bits);
            mismatches++;
            return;
        end
        want = pending_writes.pop_front();
        if (i_res.dst_row !== want.dst_row) begin
            $error("dst_row: expected %0d, got %0d", want.dst_row, i_res.dst_row);
            mismatches++;
        end
        if (i_res.dst_word_index !== want.dst_word_index) begin
            $error("dst_word_index: expected %0d, got %0d",
                   want.dst_word_index, i_res.dst_word_index);
            mismatches++;
        end
        if (i_res.or_bits !== want.or_bits) begin
            $error("or_bits: expected %h, got %h", want.or_bits, i_res.or_bits);
            mismatches++;
        end
        if (i_res.last_of_row !== want.last_of_row) begin
            $error("last_of_row: expected %0d, got %0d", want.last_of_row, i_res.last_of_row);
            mismatches++;
        end
    endtask

    // Results are checked before the edge's new word is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg = '0;
            restart_blit();
            pending_writes.delete();
        end else begin
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) check_write();
            if (i_cfg.valid === 1'b1 && i_cfg.ready === 1'b1) take_reg(i_cfg.index, i_cfg.data);
            if (i_word.valid === 1'b1 && i_word.ready === 1'b1) begin
                blit_word(i_word.src_word, i_word.row_end);
            end
        end
        o_pending <= pending_writes.size();
        o_errors  <= mismatches;
    end

endmodule

/* tb/bit_aligned_or_blit_rows_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bit_aligned_or_blit_rows_tb
// Drives register settings and rows of source words into the OR blitter,
// with random gaps on both sides, a long result stall and a drain pause.
// A directed opening covers word edges, short rows, slant and index wrap;
// random phases follow. The checker module predicts and compares.
// ---------------------------------------------------------------------------
module bit_aligned_or_blit_rows_tb;
    import bab_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          LONG_HOLD    = 300;
    localparam int          DRAIN_CYCLES = 8;
    localparam int unsigned ITEM_TARGET  = 850;
    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int          errors;
    int          pending;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned items_sent = 0;
    int unsigned cycles = 0;

    bab_word_if word_ch ();
    bab_res_if  res_ch ();
    bab_cfg_if  cfg_ch ();

    bit_aligned_or_blit_rows u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (word_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    bab_blit_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_word    (word_ch),
        .i_res     (res_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stall before each word, one long hold on request
    initial begin : result_sink
        int gap;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end
            gap = calm ? 0 : $urandom_range(0, 8);
            if (gap != 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
        end
    end

    // One source word, after a random gap
    task automatic put_word(input logic [WORD_W-1:0] w, input logic e);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            word_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        word_ch.valid    <= 1'b1;
        word_ch.src_word <= w;
        word_ch.row_end  <= e;
        do @(posedge i_clk); while (word_ch.ready !== 1'b1);
    endtask

    // One register write; the caller drops valid after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COL_W-1:0] val);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            cfg_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
    endtask

    task automatic set_layout(input logic [COL_W-1:0] first, input logic [COL_W-1:0] last_col,
                              input logic [COL_W-1:0] dst, input logic [COL_W-1:0] rows,
                              input bit ital);
        write_reg(CFG_SRC_FIRST_COL, first);
        write_reg(CFG_SRC_END_COL, last_col);
        write_reg(CFG_DST_FIRST_COL, dst);
        write_reg(CFG_ROW_COUNT, rows);
        write_reg(CFG_ITALIC_ENABLE, COL_W'(ital));
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop offering words, wait for every pending write, then let the block go quiet
    task automatic settle();
        word_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register setting and its rows; cap limits words per row (0: none)
    task automatic run_blit(input int unsigned first, input int unsigned last_col,
                            input int unsigned dst, input int unsigned rows_data,
                            input bit ital, input int unsigned cap);
        int unsigned rows, full, n;
        settle();
        set_layout(COL_W'(first), COL_W'(last_col), COL_W'(dst), COL_W'(rows_data), ital);
        rows = rows_data & 'h1FF;
        if (rows > MAX_ROWS) rows = MAX_ROWS;
        // empty span or no rows: every word is dropped
        if (rows == 0 || last_col <= first) begin
            repeat (3) put_word(WORD_W'($urandom_range(0, 16'hFFFF)),
                                1'($urandom_range(0, 1)));
            return;
        end
        for (int r = 0; r < rows; r++) begin
            full = (last_col >> 4) + 3 + $urandom_range(0, 2);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, full - 1) : full;
            if (cap != 0 && n > cap) n = cap;
            for (int i = 0; i < n; i++) begin
                put_word(WORD_W'($urandom_range(0, 16'hFFFF)), i == n - 1);
            end
            items_sent += n;
        end
        // words past the last row are dropped
        if ($urandom_range(0, 3) == 0) put_word(WORD_W'($urandom_range(0, 16'hFFFF)), 1'b1);
    endtask

    initial begin : stimulus
        int unsigned f, e, d, rw;
        word_ch.valid    <= 1'b0;
        word_ch.src_word <= '0;
        word_ch.row_end  <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.data      <= '0;
        i_rst_n          <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing configured: words are dropped
        put_word(16'hFFFF, 1'b1);
        put_word(16'h0000, 1'b0);

        // two rows, destination right of source; row 0 has one spare word
        settle();
        set_layout(13'd3, 13'd45, 13'd10, 13'd2, 1'b0);
        put_word(16'hFFFF, 1'b0);
        put_word(16'h0000, 1'b0);
        put_word(16'h8001, 1'b0);
        put_word(16'hFFFF, 1'b0);
        put_word(16'h5A5A, 1'b1);
        // sender pauses until row 0 is fully written
        settle();
        // short row: remaining writes are dropped
        put_word(16'hFFFF, 1'b0);
        put_word(16'h0000, 1'b1);
        // finished: dropped
        put_word(16'h1234, 1'b1);
        settle();
        write_reg(CFG_UNUSED, '1);
        cfg_ch.valid <= 1'b0;
        put_word(16'hFFFF, 1'b1);

        // slanted rows, span ending on a word edge, destination index wraps
        settle();
        set_layout(13'd0, 13'd16, 13'd8191, 13'd3, 1'b1);
        for (int i = 0; i < 12; i++) begin
            put_word(WORD_W'($urandom_range(0, 16'hFFFF)), (i % 4) == 3);
        end

        // reversed span is empty
        settle();
        set_layout(13'd40, 13'd20, 13'd0, 13'd4, 1'b0);
        put_word(16'hFFFF, 1'b1);
        items_sent = 24;

        // tall slanted blit, row count clamps to the limit; result side holds off
        hold_req = 1'b1;
        run_blit(5, 12, $urandom_range(0, 8191), 'h1FFF, 1'b1, 1);

        // narrow span far into the row
        f = $urandom_range(1900, 2100);
        run_blit(f, f + $urandom_range(1, 40), $urandom_range(0, 8191), 1,
                 1'($urandom_range(0, 1)), 0);

        // top of the column range: row ends long before the first write
        run_blit(8100, 8191, 8191, 1, 1'b0, 5);
        run_blit(8191, 8191, 0, 1, 1'b0, 0);

        // random settings, mostly small spans and few rows
        while (items_sent < ITEM_TARGET) begin
            calm = ($urandom_range(0, 3) == 0);
            f = $urandom_range(0, 63);
            case ($urandom_range(0, 7))
                0:       e = $urandom_range(0, f);
                1:       e = f + $urandom_range(100, 300);
                default: e = f + $urandom_range(1, 60);
            endcase
            d  = ($urandom_range(0, 3) == 0) ? $urandom_range(8000, 8191) : $urandom_range(0, 300);
            rw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            run_blit(f, e, d, rw, 1'($urandom_range(0, 1)), 0);
        end

        calm = 1'b0;
        settle();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
